// ===== design/lmts_pkg.sv =====
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types and constants for the LCD mode timing sequencer: mode codes,
// mode lengths, field widths and the per-step result bundle.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LINE_W     = 8;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned MCLK_W     = 10;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned DEF_VISIBLE_LINES = 144;
  localparam int unsigned DEF_LAST_LINE     = 153;

  // LCD mode codes, as seen on the lcd_mode field.
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  // Mode lengths.
  localparam logic [MCLK_W-1:0] LEN_HBLANK      = 10'd204;
  localparam logic [MCLK_W-1:0] LEN_VBLANK_LINE = 10'd456;
  localparam logic [MCLK_W-1:0] LEN_OAM         = 10'd80;
  localparam logic [MCLK_W-1:0] LEN_XFER        = 10'd172;

  typedef struct packed {
    logic                render_strobe;
    logic                vblank_request;
    logic [LINE_W-1:0]   line_write_value;
    logic                line_write;
    logic [LINE_W-1:0]   current_line;
    logic [MODE_W-1:0]   lcd_mode;
  } lmts_result_t;

endpackage

// ===== design/lmts_core.sv =====
// ----------------------------------------------------------------------------
// lmts_core
// Mode, mode clock and line counter registers with the single-step update
// logic. The result of a step is presented combinationally from the current
// state and the incoming cycle count; the state advances when step_en is high.
// ----------------------------------------------------------------------------
module lmts_core #(
  parameter int unsigned VISIBLE_LINES = lmts_pkg::DEF_VISIBLE_LINES,
  parameter int unsigned LAST_LINE     = lmts_pkg::DEF_LAST_LINE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic [lmts_pkg::ELAPSED_W-1:0]    elapsed_cycles,
  output lmts_pkg::lmts_result_t            result
);
  import lmts_pkg::*;

  localparam logic [LINE_W-1:0] VIS_LINE  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LAST_LN   = LINE_W'(LAST_LINE);

  logic [MODE_W-1:0] mode_r,  mode_nxt;
  logic [MCLK_W-1:0] mclk_r,  mclk_nxt;
  logic [LINE_W-1:0] line_r,  line_nxt;

  logic [MCLK_W-1:0] clk_sum;
  logic [LINE_W-1:0] line_inc;
  logic              wr;
  logic [LINE_W-1:0] wr_val;
  logic              vb;
  logic              strobe;

  // The mode clock stays below one VBLANK line between steps, so adding
  // one cycle count never overflows its width.
  assign clk_sum  = mclk_r + MCLK_W'(elapsed_cycles);
  assign line_inc = line_r + LINE_W'(1);

  always_comb begin
    mode_nxt = mode_r;
    mclk_nxt = clk_sum;
    line_nxt = line_r;
    wr       = 1'b0;
    wr_val   = '0;
    vb       = 1'b0;
    strobe   = 1'b0;
    case (mode_r)
      MODE_HBLANK: begin
        if (clk_sum >= LEN_HBLANK) begin
          mclk_nxt = '0;
          line_nxt = line_inc;
          wr       = 1'b1;
          wr_val   = line_inc;
          if (line_inc == VIS_LINE) begin
            mode_nxt = MODE_VBLANK;
            vb       = 1'b1;
          end else begin
            mode_nxt = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (clk_sum >= LEN_VBLANK_LINE) begin
          mclk_nxt = '0;
          line_nxt = line_inc;
          wr       = 1'b1;
          wr_val   = line_inc;
          // Past the last line the frame wraps; the written value still
          // reports the incremented line.
          if (line_inc > LAST_LN) begin
            mode_nxt = MODE_OAM;
            line_nxt = '0;
          end
        end
      end
      MODE_OAM: begin
        if (clk_sum >= LEN_OAM) begin
          mclk_nxt = '0;
          mode_nxt = MODE_XFER;
        end
      end
      default: begin
        if (clk_sum >= LEN_XFER) begin
          mclk_nxt = '0;
          mode_nxt = MODE_HBLANK;
          strobe   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HBLANK;
      mclk_r <= '0;
      line_r <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      mclk_r <= mclk_nxt;
      line_r <= line_nxt;
    end
  end

  always_comb begin
    result.lcd_mode         = mode_nxt;
    result.current_line     = line_nxt;
    result.line_write       = wr;
    result.line_write_value = wr_val;
    result.vblank_request   = vb;
    result.render_strobe    = strobe;
  end

endmodule

// ===== design/lcd_mode_timing_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer
// LCD mode timing: steps OAM search, pixel transfer, HBLANK and VBLANK from
// elapsed CPU cycle counts and reports line updates, vblank requests and render strobes.
// ----------------------------------------------------------------------------
// Each input request carries the time elapsed since the previous one and
// produces exactly one result request, which appears on the output register
// in the cycle after acceptance. The block accepts one request every clock: the
// whole mode update is a single add-and-compare between the state registers
// and the output register, and a new request is taken whenever the output
// register is empty or is being drained in the same cycle. A held result
// stalls the input only while out_tready stays low.
module lcd_mode_timing_sequencer #(
  parameter int unsigned VISIBLE_LINES = lmts_pkg::DEF_VISIBLE_LINES,
  parameter int unsigned LAST_LINE     = lmts_pkg::DEF_LAST_LINE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] elapsed_cycles
  input  logic [lmts_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] lcd_mode, [9:2] current_line, [10] line_write,
  // [18:11] line_write_value, [19] vblank_request, [20] render_strobe,
  // [23:21] zero
  output logic [lmts_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import lmts_pkg::*;

  logic         in_fire;
  lmts_result_t step_res;
  lmts_result_t res_r;
  logic         out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  lmts_core #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (in_fire),
    .elapsed_cycles (in_tdata[ELAPSED_W-1:0]),
    .result         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       res_r.render_strobe,
                       res_r.vblank_request,
                       res_r.line_write_value,
                       res_r.line_write,
                       res_r.current_line,
                       res_r.lcd_mode};

endmodule

// ===== design/lmts_checker.sv =====
// ----------------------------------------------------------------------------
// lmts_checker
// Port-level checks for the LCD mode timing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lmts_checker #(
  parameter int unsigned VISIBLE_LINES = lmts_pkg::DEF_VISIBLE_LINES
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [lmts_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import lmts_pkg::*;

  localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An empty output register never blocks a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A vblank request only comes with the entry into VBLANK at the visible height.
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |->
      out_tdata[1:0] == MODE_VBLANK && out_tdata[9:2] == VIS_LINE &&
      out_tdata[10] && out_tdata[18:11] == VIS_LINE)
    else $error("vblank request outside VBLANK entry");

  // A render strobe marks the change from transfer to HBLANK, without a line write.
  a_strobe_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |->
      out_tdata[1:0] == MODE_HBLANK && !out_tdata[10] && !out_tdata[19])
    else $error("render strobe outside transfer exit");

  // Without a line write the written value field is zero.
  a_wr_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[18:11] == '0)
    else $error("line value without line write");

endmodule

bind lcd_mode_timing_sequencer lmts_checker #(
  .VISIBLE_LINES (VISIBLE_LINES)
) u_lmts_checker (.*);
